// ----- sv/modular_exponentiation_assert.svh -----
// assertion macros shared by the modular exponentiation rtl
// expects signals named clock and reset in the including module
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MX_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MX_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- sv/modexp_pkg.sv -----
// shared types and constants for the modular exponentiation block
// no dependencies
package modexp_pkg;

   localparam int DATA_WIDTH            = 63;
   localparam int OPERAND_WIDTH_DEFAULT = 63;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] base_value;
      logic [DATA_WIDTH-1:0] exponent;
      logic [DATA_WIDTH-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] power_result;
      logic                  modulus_error;
   } rsp_type;

endpackage

// ----- sv/modular_exponentiation.sv -----
// modular exponentiation, right-to-left square and multiply on one shared mulmod unit
// steps: one mulmod to reduce the base, then per exponent bit up to the top set bit
// a squaring, preceded by a multiply into the accumulator when that bit is set
// one request at a time, next request taken once the result is registered
// a zero or one modulus skips the loop and answers zero; reset clears the sequencer and output valid
// depends on modexp_pkg, modexp_mulmod and modular_exponentiation_assert.svh
`include "modular_exponentiation_assert.svh"

module modular_exponentiation
   import modexp_pkg::*;
#(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int W = OPERAND_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_FINISH
   } state_type;

   state_type    state_ff;
   logic         start_ff;
   logic [W-1:0] opx_ff;
   logic [W-1:0] opy_ff;
   logic [W-1:0] mod_ff;
   logic [W-1:0] exp_ff;
   logic [W-1:0] acc_ff;
   logic [W-1:0] sq_ff;
   logic         err_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;

   logic         mm_done;
   logic [W-1:0] mm_product;
   logic [W-1:0] base_w;
   logic [W-1:0] exp_w;
   logic [W-1:0] mod_w;
   logic         accept;

   assign base_w = W'(req_data.base_value);
   assign exp_w  = W'(req_data.exponent);
   assign mod_w  = W'(req_data.modulus);
   assign accept = req_valid && req_ready;

   modexp_mulmod #(
      .W(W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .x       (opx_ff),
      .y       (opy_ff),
      .m       (mod_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               start_ff <= accept && (mod_w > W'(1));
               if (accept) begin
                  mod_ff <= mod_w;
                  exp_ff <= exp_w;
                  err_ff <= (mod_w == '0);
                  if (mod_w <= W'(1)) begin
                     acc_ff   <= '0;
                     state_ff <= ST_FINISH;
                  end else begin
                     // base mod m as 1 * base mod m
                     acc_ff   <= W'(1);
                     opx_ff   <= W'(1);
                     opy_ff   <= base_w;
                     state_ff <= ST_REDUCE;
                  end
               end
            end
            ST_REDUCE: begin
               start_ff <= 1'b0;
               if (mm_done) begin
                  sq_ff    <= mm_product;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               start_ff <= (exp_ff != '0);
               if (exp_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else if (exp_ff[0]) begin
                  opx_ff   <= acc_ff;
                  opy_ff   <= sq_ff;
                  state_ff <= ST_MUL_ACC;
               end else begin
                  opx_ff   <= sq_ff;
                  opy_ff   <= sq_ff;
                  state_ff <= ST_MUL_SQ;
               end
            end
            ST_MUL_ACC: begin
               start_ff <= mm_done;
               if (mm_done) begin
                  acc_ff   <= mm_product;
                  opx_ff   <= sq_ff;
                  opy_ff   <= sq_ff;
                  state_ff <= ST_MUL_SQ;
               end
            end
            ST_MUL_SQ: begin
               start_ff <= 1'b0;
               if (mm_done) begin
                  sq_ff    <= mm_product;
                  exp_ff   <= exp_ff >> 1;
                  state_ff <= ST_CHECK;
               end
            end
            ST_FINISH: begin
               start_ff <= 1'b0;
               // hold until the output slot is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.power_result  <= DATA_WIDTH'(acc_ff);
                  rsp_data_ff.modulus_error <= err_ff;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: begin
               start_ff <= 1'b0;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MX_ASSERT_NEXT(a_accept_busy, accept, state_ff != ST_IDLE, "request taken but still idle")
   `MX_ASSERT_IMPL(a_err_zero, rsp_valid_ff && rsp_data_ff.modulus_error,
                   rsp_data_ff.power_result == '0, "error result not zero")
   `MX_ASSERT_IMPL(a_acc_reduced, state_ff == ST_CHECK, (acc_ff < mod_ff) && (sq_ff < mod_ff),
                   "loop operands not reduced")
   `MX_ASSERT_IMPL(a_done_waiting, mm_done,
                   state_ff == ST_REDUCE || state_ff == ST_MUL_ACC || state_ff == ST_MUL_SQ,
                   "multiplier finished with no one waiting")

endmodule

// ----- sv/modexp_mulmod.sv -----
// iterative modular multiplier: x * y mod m, one multiplier bit per cycle
// depends on modexp_pkg and modular_exponentiation_assert.svh
`include "modular_exponentiation_assert.svh"

module modexp_mulmod
   import modexp_pkg::*;
#(
   parameter int W = OPERAND_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] x,
   input  logic [W-1:0] y,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] product
);

   localparam int TW = W + 2;
   localparam int CW = $clog2(W);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] count_ff;
   logic [W-1:0]  acc_ff;
   logic [W-1:0]  x_ff;
   logic [W-1:0]  y_ff;
   logic [W-1:0]  m_ff;

   logic [W-1:0]  addend;
   logic [TW-1:0] sum_w;
   logic [TW-1:0] mod1_w;
   logic [TW-1:0] mod2_w;
   logic [W-1:0]  acc_in;

   // 2*acc + x*bit stays below 3m, so at most two subtractions of m
   assign addend = y_ff[W-1] ? x_ff : '0;
   assign sum_w  = {1'b0, acc_ff, 1'b0} + {2'b00, addend};
   assign mod1_w = {2'b00, m_ff};
   assign mod2_w = {1'b0, m_ff, 1'b0};

   always_comb begin
      priority if (sum_w >= mod2_w) begin
         acc_in = W'(sum_w - mod2_w);
      end else if (sum_w >= mod1_w) begin
         acc_in = W'(sum_w - mod1_w);
      end else begin
         acc_in = W'(sum_w);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && !start && (count_ff == '0);
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CW'(W - 1);
            acc_ff   <= '0;
            x_ff     <= x;
            y_ff     <= y;
            m_ff     <= m;
         end else if (busy_ff) begin
            acc_ff   <= acc_in;
            y_ff     <= {y_ff[W-2:0], 1'b0};
            count_ff <= count_ff - CW'(1);
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

   `MX_ASSERT_NEXT(a_start_busy, start, busy_ff, "multiplier did not start")
   `MX_ASSERT_IMPL(a_done_idle, done_ff, !busy_ff, "done while still busy")
   `MX_ASSERT_IMPL(a_acc_reduced, busy_ff, acc_ff < m_ff, "partial sum not reduced")

endmodule
